// ===== sv/udv_pkg.sv =====
package udv_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int FIELD_BITS  = 32;
  localparam int WIDE_BITS   = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [FIELD_BITS-1:0]  field_t;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_BOM     = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LEAD_ASCII = 2'd0,
    LEAD_OPEN  = 2'd1,
    LEAD_BAD   = 2'd2
  } lead_kind_t;

  localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
  localparam logic [7:0] BYTE_TWO_MIN   = 8'hC2;
  localparam logic [7:0] BYTE_TWO_MAX   = 8'hDF;
  localparam logic [7:0] BYTE_E0        = 8'hE0;
  localparam logic [7:0] BYTE_ED        = 8'hED;
  localparam logic [7:0] BYTE_THREE_MAX = 8'hEF;
  localparam logic [7:0] BYTE_F0        = 8'hF0;
  localparam logic [7:0] BYTE_F4        = 8'hF4;
  localparam logic [7:0] TRAIL_LOW      = 8'h80;
  localparam logic [7:0] TRAIL_HIGH     = 8'hBF;
  localparam logic [7:0] E0_LOW         = 8'hA0;
  localparam logic [7:0] ED_HIGH        = 8'h9F;
  localparam logic [7:0] F0_LOW         = 8'h90;
  localparam logic [7:0] F4_HIGH        = 8'h8F;

  localparam logic [7:0] BOM_BYTE0 = 8'hEF;
  localparam logic [7:0] BOM_BYTE1 = 8'hBB;
  localparam logic [7:0] BOM_BYTE2 = 8'hBF;
  localparam logic [1:0] BOM_DONE  = 2'd3;
  localparam field_t     BOM_END   = FIELD_BITS'(3);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } udv_in_t;

  typedef struct packed {
    status_t status;
    field_t  error_begin;
    field_t  error_end;
    field_t  text_length;
  } udv_out_t;

  typedef struct packed {
    logic    valid;
    udv_in_t item;
  } udv_beat_t;

  typedef struct packed {
    lead_kind_t kind;
    logic [2:0] seq_len;
    logic [7:0] low;
    logic [7:0] high;
  } lead_info_t;

  function automatic offset_t sat_inc(input offset_t v);
    return (v == '1) ? v : v + offset_t'(1);
  endfunction

  function automatic field_t clamp_field(input offset_t v);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(v);
    return (w > WIDE_BITS'({FIELD_BITS{1'b1}})) ? '1 : w[FIELD_BITS-1:0];
  endfunction

endpackage

// ===== sv/udv_in_stage.sv =====
module udv_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_ready,
  input  udv_pkg::udv_in_t text_item,
  output udv_pkg::udv_beat_t beat,
  input  logic             take
);
  import udv_pkg::*;

  logic    valid;
  udv_in_t item;

  assign text_ready = !valid || take;
  assign beat       = '{valid: valid, item: item};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (text_ready) begin
      valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_ready && text_valid) begin
      item <= text_item;
    end
  end

endmodule

// ===== sv/udv_lead_dec.sv =====
module udv_lead_dec (
  input  logic [7:0]          data_byte,
  output udv_pkg::lead_info_t info
);
  import udv_pkg::*;

  always_comb begin
    info = '{kind: LEAD_BAD, seq_len: 3'd0, low: TRAIL_LOW, high: TRAIL_HIGH};
    if (data_byte <= BYTE_ASCII_MAX) begin
      info.kind = LEAD_ASCII;
    end else if (data_byte >= BYTE_TWO_MIN && data_byte <= BYTE_TWO_MAX) begin
      info.kind    = LEAD_OPEN;
      info.seq_len = 3'd2;
    end else if (data_byte >= BYTE_E0 && data_byte <= BYTE_THREE_MAX) begin
      info.kind    = LEAD_OPEN;
      info.seq_len = 3'd3;
      if (data_byte == BYTE_E0) begin
        info.low = E0_LOW;
      end else if (data_byte == BYTE_ED) begin
        info.high = ED_HIGH;
      end
    end else if (data_byte >= BYTE_F0 && data_byte <= BYTE_F4) begin
      info.kind    = LEAD_OPEN;
      info.seq_len = 3'd4;
      if (data_byte == BYTE_F0) begin
        info.low = F0_LOW;
      end else if (data_byte == BYTE_F4) begin
        info.high = F4_HIGH;
      end
    end
  end

endmodule

// ===== sv/udv_core.sv =====
module udv_core (
  input  logic               clk,
  input  logic               rst,
  input  udv_pkg::udv_beat_t beat,
  output logic               take,
  input  logic               reject_bom,
  output logic               verdict_valid,
  input  logic               verdict_ready,
  output udv_pkg::udv_out_t  verdict_item
);
  import udv_pkg::*;

  offset_t    byte_offset, byte_offset_next;
  offset_t    seq_start, seq_start_next;
  logic [2:0] seq_length, seq_length_next;
  logic [2:0] seq_seen, seq_seen_next;
  logic [7:0] second_low, second_low_next;
  logic [7:0] second_high, second_high_next;
  logic       pending_fail, pending_fail_next;
  offset_t    pending_end, pending_end_next;
  logic       error_found, error_found_next;
  offset_t    found_begin, found_begin_next;
  offset_t    found_end, found_end_next;
  logic [1:0] bom_progress, bom_progress_next;
  logic       verdict_valid_next;
  udv_out_t   verdict_item_next;

  lead_info_t lead;
  offset_t    cur;
  offset_t    cur_inc;
  logic [7:0] b;
  logic [7:0] lo;
  logic [7:0] hi;

  udv_lead_dec u_lead_dec (
    .data_byte (beat.item.data_byte),
    .info      (lead)
  );

  assign take = beat.valid && (!beat.item.last_byte || !verdict_valid || verdict_ready);

  always_comb begin
    byte_offset_next   = byte_offset;
    seq_start_next     = seq_start;
    seq_length_next    = seq_length;
    seq_seen_next      = seq_seen;
    second_low_next    = second_low;
    second_high_next   = second_high;
    pending_fail_next  = pending_fail;
    pending_end_next   = pending_end;
    error_found_next   = error_found;
    found_begin_next   = found_begin;
    found_end_next     = found_end;
    bom_progress_next  = bom_progress;
    verdict_valid_next = verdict_valid && !verdict_ready;
    verdict_item_next  = verdict_item;

    b       = beat.item.data_byte;
    cur     = byte_offset;
    cur_inc = sat_inc(cur);
    lo      = (seq_seen == 3'd1) ? second_low : TRAIL_LOW;
    hi      = (seq_seen == 3'd1) ? second_high : TRAIL_HIGH;

    if (take) begin
      if (cur == offset_t'(0) && b == BOM_BYTE0 && bom_progress == 2'd0) begin
        bom_progress_next = 2'd1;
      end else if (cur == offset_t'(1) && b == BOM_BYTE1 && bom_progress == 2'd1) begin
        bom_progress_next = 2'd2;
      end else if (cur == offset_t'(2) && b == BOM_BYTE2 && bom_progress == 2'd2) begin
        bom_progress_next = BOM_DONE;
      end

      if (!error_found) begin
        if (seq_length != 3'd0) begin
          if (!pending_fail && (b < lo || b > hi)) begin
            pending_fail_next = 1'b1;
            pending_end_next  = cur_inc;
          end
          seq_seen_next = seq_seen + 3'd1;
          if (seq_seen_next >= seq_length) begin
            seq_length_next = 3'd0;
            seq_seen_next   = 3'd0;
            if (pending_fail_next) begin
              error_found_next = 1'b1;
              found_begin_next = seq_start;
              found_end_next   = pending_end_next;
            end
            pending_fail_next = 1'b0;
          end
        end else begin
          case (lead.kind)
            LEAD_OPEN: begin
              seq_start_next    = cur;
              seq_length_next   = lead.seq_len;
              seq_seen_next     = 3'd1;
              second_low_next   = lead.low;
              second_high_next  = lead.high;
              pending_fail_next = 1'b0;
              pending_end_next  = '0;
            end
            LEAD_BAD: begin
              error_found_next = 1'b1;
              found_begin_next = cur;
              found_end_next   = cur_inc;
            end
            default: begin
            end
          endcase
        end
      end
      byte_offset_next = cur_inc;

      if (beat.item.last_byte) begin
        // text ends inside an open sequence: truncation
        if (!error_found_next && seq_length_next != 3'd0) begin
          error_found_next = 1'b1;
          found_begin_next = seq_start_next;
          found_end_next   = cur_inc;
        end
        verdict_valid_next            = 1'b1;
        verdict_item_next.text_length = clamp_field(cur_inc);
        if (reject_bom && bom_progress_next == BOM_DONE) begin
          verdict_item_next.status      = STATUS_BOM;
          verdict_item_next.error_begin = '0;
          verdict_item_next.error_end   = BOM_END;
        end else if (error_found_next) begin
          verdict_item_next.status      = STATUS_INVALID;
          verdict_item_next.error_begin = clamp_field(found_begin_next);
          verdict_item_next.error_end   = clamp_field(found_end_next);
        end else begin
          verdict_item_next.status      = STATUS_VALID;
          verdict_item_next.error_begin = '0;
          verdict_item_next.error_end   = '0;
        end
        byte_offset_next  = '0;
        seq_start_next    = '0;
        seq_length_next   = 3'd0;
        seq_seen_next     = 3'd0;
        second_low_next   = TRAIL_LOW;
        second_high_next  = TRAIL_HIGH;
        pending_fail_next = 1'b0;
        pending_end_next  = '0;
        error_found_next  = 1'b0;
        found_begin_next  = '0;
        found_end_next    = '0;
        bom_progress_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      seq_start     <= '0;
      seq_length    <= 3'd0;
      seq_seen      <= 3'd0;
      second_low    <= TRAIL_LOW;
      second_high   <= TRAIL_HIGH;
      pending_fail  <= 1'b0;
      pending_end   <= '0;
      error_found   <= 1'b0;
      found_begin   <= '0;
      found_end     <= '0;
      bom_progress  <= 2'd0;
      verdict_valid <= 1'b0;
    end else begin
      byte_offset   <= byte_offset_next;
      seq_start     <= seq_start_next;
      seq_length    <= seq_length_next;
      seq_seen      <= seq_seen_next;
      second_low    <= second_low_next;
      second_high   <= second_high_next;
      pending_fail  <= pending_fail_next;
      pending_end   <= pending_end_next;
      error_found   <= error_found_next;
      found_begin   <= found_begin_next;
      found_end     <= found_end_next;
      bom_progress  <= bom_progress_next;
      verdict_valid <= verdict_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    verdict_item <= verdict_item_next;
  end

endmodule

// ===== sv/utf8_stream_validator.sv =====
// Channel   Dir  Handshake                    Beat
// text      in   text_valid / text_ready      text_item: data_byte, last_byte
// verdict   out  verdict_valid / verdict_ready verdict_item: status, begin, end, length
// cfg       in   cfg_we, no wait              cfg_wdata: reject_bom
//
// One byte per cycle. A byte waits in the input register until the core takes it
// and folds it into the text state; a last byte that is taken also loads the verdict
// register, which holds the verdict until verdict_ready.
// Reset is synchronous; it empties both registers and sets reject_bom.
// A waiting verdict holds back only a last byte; behind it text_ready drops.
module utf8_stream_validator (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  output logic              text_ready,
  input  udv_pkg::udv_in_t  text_item,
  output logic              verdict_valid,
  input  logic              verdict_ready,
  output udv_pkg::udv_out_t verdict_item,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import udv_pkg::*;

  udv_beat_t beat;
  logic      take;
  logic      reject_bom;

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_bom <= 1'b1;
    end else if (cfg_we) begin
      reject_bom <= cfg_wdata;
    end
  end

  udv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item),
    .beat       (beat),
    .take       (take)
  );

  udv_core u_core (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .take          (take),
    .reject_bom    (reject_bom),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict_item  (verdict_item)
  );

endmodule

// ===== sv/udv_checker.sv =====
module udv_checker (
  input logic              clk,
  input logic              rst,
  input logic              verdict_valid,
  input logic              verdict_ready,
  input udv_pkg::udv_out_t verdict_item
);
  import udv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict_item))
    else $error("verdict beat dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !verdict_valid)
    else $error("verdict valid after reset");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_item.status == STATUS_VALID |->
      verdict_item.error_begin == '0 && verdict_item.error_end == '0)
    else $error("valid text with nonzero error span");

  a_bom: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_item.status == STATUS_BOM |->
      verdict_item.error_begin == '0 && verdict_item.error_end == BOM_END &&
      verdict_item.text_length >= BOM_END)
    else $error("bad byte order mark verdict");

  a_span: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |->
      (verdict_item.status == STATUS_VALID || verdict_item.status == STATUS_BOM ||
       (verdict_item.status == STATUS_INVALID &&
        verdict_item.error_begin <= verdict_item.error_end &&
        verdict_item.error_end <= verdict_item.text_length)))
    else $error("error span outside the text or unknown status");

endmodule

bind utf8_stream_validator udv_checker u_udv_checker (
  .clk           (clk),
  .rst           (rst),
  .verdict_valid (verdict_valid),
  .verdict_ready (verdict_ready),
  .verdict_item  (verdict_item)
);

// ===== test/utf8_stream_validator_test.sv =====
`timescale 1ns / 100ps

module utf8_stream_validator_test;
  import udv_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_PCT     = 34;

  typedef logic [7:0] octets_t [$];

  logic     clk;
  logic     rst = 1'b1;
  logic     text_valid = 1'b0;
  logic     text_ready;
  udv_in_t  text_item = '0;
  logic     verdict_valid;
  logic     verdict_ready = 1'b0;
  udv_out_t verdict_item;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;

  bit       calm = 1'b0;
  int       fails = 0;
  int       cycles = 0;
  int       bytes_sent = 0;
  udv_out_t verdicts_due [$];
  udv_out_t want;

  // predicted text state
  logic       reject_bom_m = 1'b1;
  offset_t    txt_len, seq_begin, bad_end, err_begin, err_end;
  logic [2:0] seq_need, seq_got;
  logic [7:0] second_lo, second_hi;
  logic       bad_pending, err_seen;
  status_t    err_status;
  logic [1:0] bom_step;

  utf8_stream_validator i_dut (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text_item     (text_item),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict_item  (verdict_item),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) verdict_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (!rst && verdict_valid && verdict_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict beat with none expected: status %0d", verdict_item.status);
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        if (verdict_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, verdict_item.status);
          fails++;
        end
        if (verdict_item.error_begin !== want.error_begin) begin
          $error("error_begin: expected %0d, got %0d", want.error_begin,
                 verdict_item.error_begin);
          fails++;
        end
        if (verdict_item.error_end !== want.error_end) begin
          $error("error_end: expected %0d, got %0d", want.error_end, verdict_item.error_end);
          fails++;
        end
        if (verdict_item.text_length !== want.text_length) begin
          $error("text_length: expected %0d, got %0d", want.text_length,
                 verdict_item.text_length);
          fails++;
        end
      end
    end
  end

  function automatic offset_t bump(input offset_t v);
    return v + offset_t'(v != '1);
  endfunction

  function automatic void clear_text();
    txt_len     = '0;
    seq_begin   = '0;
    seq_need    = '0;
    seq_got     = '0;
    second_lo   = TRAIL_LOW;
    second_hi   = TRAIL_HIGH;
    bad_pending = 1'b0;
    bad_end     = '0;
    err_seen    = 1'b0;
    err_status  = STATUS_VALID;
    err_begin   = '0;
    err_end     = '0;
    bom_step    = '0;
  endfunction

  function automatic void flag_bad(input offset_t b, input offset_t e);
    err_seen   = 1'b1;
    err_status = STATUS_INVALID;
    err_begin  = b;
    err_end    = e;
  endfunction

  function automatic void start_seq(input offset_t pos, input logic [2:0] len,
                                    input logic [7:0] lo, input logic [7:0] hi);
    seq_begin   = pos;
    seq_need    = len;
    seq_got     = 3'd1;
    second_lo   = lo;
    second_hi   = hi;
    bad_pending = 1'b0;
    bad_end     = '0;
  endfunction

  // fold one accepted beat into the predicted state; a last byte yields a verdict
  function automatic void track_byte(input udv_in_t it);
    offset_t    pos;
    logic [7:0] b, lo, hi;
    udv_out_t   v;
    pos = txt_len;
    b   = it.data_byte;
    if (pos == 0 && b == BOM_BYTE0 && bom_step == 2'd0) bom_step = 2'd1;
    else if (pos == 1 && b == BOM_BYTE1 && bom_step == 2'd1) bom_step = 2'd2;
    else if (pos == 2 && b == BOM_BYTE2 && bom_step == 2'd2) bom_step = BOM_DONE;
    if (!err_seen) begin
      if (seq_need != 0) begin
        lo = (seq_got == 3'd1) ? second_lo : TRAIL_LOW;
        hi = (seq_got == 3'd1) ? second_hi : TRAIL_HIGH;
        if (!bad_pending && (b < lo || b > hi)) begin
          bad_pending = 1'b1;
          bad_end     = bump(pos);
        end
        seq_got++;
        if (seq_got >= seq_need) begin
          seq_need = '0;
          seq_got  = '0;
          if (bad_pending) flag_bad(seq_begin, bad_end);
          bad_pending = 1'b0;
        end
      end else if (b > BYTE_ASCII_MAX) begin
        if (b >= BYTE_TWO_MIN && b <= BYTE_TWO_MAX) start_seq(pos, 3'd2, TRAIL_LOW, TRAIL_HIGH);
        else if (b == BYTE_E0) start_seq(pos, 3'd3, E0_LOW, TRAIL_HIGH);
        else if (b == BYTE_ED) start_seq(pos, 3'd3, TRAIL_LOW, ED_HIGH);
        else if (b > BYTE_E0 && b <= BYTE_THREE_MAX) start_seq(pos, 3'd3, TRAIL_LOW, TRAIL_HIGH);
        else if (b == BYTE_F0) start_seq(pos, 3'd4, F0_LOW, TRAIL_HIGH);
        else if (b > BYTE_F0 && b < BYTE_F4) start_seq(pos, 3'd4, TRAIL_LOW, TRAIL_HIGH);
        else if (b == BYTE_F4) start_seq(pos, 3'd4, TRAIL_LOW, F4_HIGH);
        else flag_bad(pos, bump(pos));
      end
    end
    txt_len = bump(pos);
    if (it.last_byte) begin
      if (!err_seen && seq_need != 0) flag_bad(seq_begin, txt_len);
      if (reject_bom_m && bom_step == BOM_DONE)
        v = '{status: STATUS_BOM, error_begin: '0, error_end: BOM_END,
              text_length: field_t'(txt_len)};
      else if (err_seen)
        v = '{status: err_status, error_begin: field_t'(err_begin),
              error_end: field_t'(err_end), text_length: field_t'(txt_len)};
      else
        v = '{status: STATUS_VALID, error_begin: '0, error_end: '0,
              text_length: field_t'(txt_len)};
      verdicts_due = {verdicts_due, v};
      clear_text();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= '{data_byte: b, last_byte: fin};
    do @(posedge clk); while (!text_ready);
    track_byte('{data_byte: b, last_byte: fin});
    bytes_sent++;
  endtask

  task automatic send_text(input octets_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // sender holds off until every verdict is back and the pipe has emptied
  task automatic settle();
    @(negedge clk);
    text_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reject_bom(input logic v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    reject_bom_m = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic octets_t utf8_char(input int len);
    octets_t c;
    case (len)
      1: c = '{8'($urandom_range(BYTE_ASCII_MAX))};
      2: c = '{8'($urandom_range(BYTE_TWO_MAX, BYTE_TWO_MIN))};
      3: c = '{8'($urandom_range(BYTE_THREE_MAX, BYTE_E0))};
      default: c = '{8'($urandom_range(BYTE_F4, BYTE_F0))};
    endcase
    for (int i = 1; i < len; i++) c = {c, 8'($urandom_range(TRAIL_HIGH, TRAIL_LOW))};
    if (len > 1) begin
      case (c[0])
        BYTE_E0: c[1] = 8'($urandom_range(TRAIL_HIGH, E0_LOW));
        BYTE_ED: c[1] = 8'($urandom_range(ED_HIGH, TRAIL_LOW));
        BYTE_F0: c[1] = 8'($urandom_range(TRAIL_HIGH, F0_LOW));
        BYTE_F4: c[1] = 8'($urandom_range(F4_HIGH, TRAIL_LOW));
        default: ;
      endcase
    end
    return c;
  endfunction

  // mostly well-formed characters, some noise bytes and broken sequences
  task automatic send_random_text();
    octets_t q, c;
    int      chars, k;
    chars = ($urandom_range(19) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
    if ($urandom_range(9) == 0) q = '{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2};
    repeat (chars) begin
      k = $urandom_range(99);
      if (k < 80) begin
        c = utf8_char($urandom_range(4, 1));
      end else if (k < 90) begin
        c = '{8'($urandom)};
      end else begin
        c = utf8_char($urandom_range(4, 2));
        if ($urandom_range(1)) void'(c.pop_back());
        else c[$urandom_range(c.size() - 1, 1)] = 8'($urandom);
      end
      q = {q, c};
    end
    send_text(q);
  endtask

  task automatic test_directed();
    send_text('{8'h00});
    send_text('{8'hFF});
    send_text('{8'hC1});
    send_text('{8'h7F, 8'hDF, 8'hBF});
    send_text('{8'hE0, 8'h9F, 8'h80});
    send_text('{8'hED, 8'hA0});
    send_text('{8'hF4, 8'h90, 8'h80, 8'h80});
    send_text('{8'hF0, 8'h90, 8'h80});
    send_text('{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2});
    send_text('{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2, 8'hFF});
  endtask

  task automatic test_bom_setting();
    write_reject_bom(1'b0);
    send_text('{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2});
    send_text('{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2, 8'hF5});
    write_reject_bom(1'b1);
    send_text('{BOM_BYTE0, BOM_BYTE1});
    send_text('{8'hFF, 8'hC2});
  endtask

  task automatic test_long_text();
    octets_t q;
    repeat (80) q = {q, utf8_char($urandom_range(4, 1))};
    send_text(q);
    q = {};
    repeat (70) q = {q, utf8_char($urandom_range(4, 1))};
    q = {q, 8'hFE};
    repeat (10) q = {q, utf8_char($urandom_range(4, 1))};
    send_text(q);
  endtask

  task automatic test_random_phase(input logic rej, input int n);
    int target;
    write_reject_bom(rej);
    target = bytes_sent + n;
    while (bytes_sent < target) send_random_text();
  endtask

  initial begin
    clear_text();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_bom_setting();
    test_long_text();
    test_random_phase(1'b1, 350);
    calm = 1'b1;
    test_random_phase(1'b0, 200);
    calm = 1'b0;
    test_random_phase(1'b0, 200);
    test_random_phase(1'b1, 250);
    settle();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
